// File: rtl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// pbt_pkg
// Types, codes and sizes shared by the partition budget tracker.
// ----------------------------------------------------------------------------
package pbt_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] ACT_RESET_ALL  = 3'd0;
  localparam logic [2:0] ACT_CREATE     = 3'd1;
  localparam logic [2:0] ACT_DESTROY    = 3'd2;
  localparam logic [2:0] ACT_RESET_PART = 3'd3;
  localparam logic [2:0] ACT_ALLOC      = 3'd4;
  localparam logic [2:0] ACT_QUERY      = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_FIT   = 2'd1;
  localparam logic [1:0] STAT_INACTIVE = 2'd2;

  localparam int PADDR_W = 3;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  slot_index;
    logic [31:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [31:0] slot_free;
    logic [31:0] slot_total;
    logic [31:0] pool_free;
  } rsp_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] free;
  } slot_entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    slot_entry_t        data;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
  } mem_rd_t;

endpackage

// File: rtl/pbt_apb_regs.sv
// ----------------------------------------------------------------------------
// pbt_apb_regs
// APB register file holding the pool size.
// ----------------------------------------------------------------------------
module pbt_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [31:0]                  pool_size
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[pbt_pkg::PADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= 32'd0;
    end else if (psel && penable && pwrite && hit) begin
      pool_size <= pwdata;
    end
  end

  assign prdata = hit ? pool_size : 32'd0;

endmodule

// File: rtl/pbt_slot_mem.sv
// ----------------------------------------------------------------------------
// pbt_slot_mem
// Slot amount memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbt_slot_mem (
  input  logic                  clk,
  input  pbt_pkg::mem_rd_t      rd,
  output pbt_pkg::slot_entry_t  rd_data,
  input  pbt_pkg::mem_wr_t      wr
);

  pbt_pkg::slot_entry_t mem [pbt_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// File: rtl/partition_budget_tracker.sv
// ----------------------------------------------------------------------------
// partition_budget_tracker
// Pool budget tracker over partition slots; slot amounts kept in memory.
// ----------------------------------------------------------------------------
// The slot memory read is registered, then the request commits to the
// response register with write-back, waiting while a stalled response is held;
// the next is taken after that commit, and may transfer while a response waits.
// Reset: slot active flags, pool free amount and pool size clear at once;
// slot memory is not cleared (inactive slots read as zero).
module partition_budget_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  pbt_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output pbt_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbt_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                          state;
  logic                          state_next;
  pbt_pkg::req_t                 req_q;
  logic [pbt_pkg::SLOTS-1:0]     active;
  logic [pbt_pkg::SLOTS-1:0]     active_next;
  logic [31:0]                   pool_free;
  logic [31:0]                   pool_free_next;
  logic [31:0]                   pool_size;
  pbt_pkg::mem_rd_t              mem_rd;
  pbt_pkg::mem_wr_t              mem_wr;
  pbt_pkg::slot_entry_t          rd_data;
  pbt_pkg::rsp_t                 rsp_next;
  logic                          accept;
  logic                          commit;
  logic                          in_range;
  logic                          slot_on;
  logic [pbt_pkg::SLOT_AW-1:0]   addr;
  logic                          found;
  logic [pbt_pkg::SLOT_AW-1:0]   free_idx;
  logic [31:0]                   rep_free;
  logic [31:0]                   rep_total;

  pbt_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pool_size (pool_size)
  );

  pbt_slot_mem u_mem (
    .clk     (clk),
    .rd      (mem_rd),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state == ST_EXEC) && (!rsp_valid || rsp_ready);

  assign mem_rd.en   = accept;
  assign mem_rd.addr = pbt_pkg::SLOT_AW'(req.slot_index);

  assign in_range  = ({28'd0, req_q.slot_index} < 32'(pbt_pkg::SLOTS));
  assign addr      = pbt_pkg::SLOT_AW'(req_q.slot_index);
  assign slot_on   = in_range && active[addr];
  assign rep_free  = slot_on ? rd_data.free : 32'd0;
  assign rep_total = slot_on ? rd_data.total : 32'd0;

  // lowest inactive slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = pbt_pkg::SLOTS - 1; s >= 0; s--) begin
      if (!active[s]) begin
        found    = 1'b1;
        free_idx = pbt_pkg::SLOT_AW'(s);
      end
    end
  end

  always_comb begin
    active_next           = active;
    pool_free_next        = pool_free;
    mem_wr.en             = 1'b0;
    mem_wr.addr           = addr;
    mem_wr.data           = rd_data;
    rsp_next.status       = pbt_pkg::STAT_OK;
    rsp_next.granted_slot = req_q.slot_index;
    rsp_next.slot_free    = rep_free;
    rsp_next.slot_total   = rep_total;
    case (req_q.action)
      pbt_pkg::ACT_RESET_ALL: begin
        active_next         = '0;
        pool_free_next      = pool_size;
        rsp_next.slot_free  = 32'd0;
        rsp_next.slot_total = 32'd0;
      end
      pbt_pkg::ACT_CREATE: begin
        if (found && (req_q.request_size <= pool_free)) begin
          active_next[free_idx] = 1'b1;
          pool_free_next        = pool_free - req_q.request_size;
          mem_wr.en             = 1'b1;
          mem_wr.addr           = free_idx;
          mem_wr.data.total     = req_q.request_size;
          mem_wr.data.free      = req_q.request_size;
          rsp_next.granted_slot = 4'(free_idx);
          rsp_next.slot_free    = req_q.request_size;
          rsp_next.slot_total   = req_q.request_size;
        end else begin
          rsp_next.status = pbt_pkg::STAT_NO_FIT;
        end
      end
      pbt_pkg::ACT_DESTROY: begin
        if (!slot_on) begin
          rsp_next.status = pbt_pkg::STAT_INACTIVE;
        end else begin
          active_next[addr]   = 1'b0;
          rsp_next.slot_free  = 32'd0;
          rsp_next.slot_total = 32'd0;
        end
      end
      pbt_pkg::ACT_RESET_PART: begin
        if (!slot_on) begin
          rsp_next.status = pbt_pkg::STAT_INACTIVE;
        end else begin
          mem_wr.en          = 1'b1;
          mem_wr.data.free   = rd_data.total;
          rsp_next.slot_free = rd_data.total;
        end
      end
      pbt_pkg::ACT_ALLOC: begin
        if (!slot_on) begin
          rsp_next.status = pbt_pkg::STAT_INACTIVE;
        end else if (rd_data.free < req_q.request_size) begin
          rsp_next.status = pbt_pkg::STAT_NO_FIT;
        end else begin
          mem_wr.en          = 1'b1;
          mem_wr.data.free   = rd_data.free - req_q.request_size;
          rsp_next.slot_free = rd_data.free - req_q.request_size;
        end
      end
      default: begin
        if (!slot_on) begin
          rsp_next.status = pbt_pkg::STAT_INACTIVE;
        end
      end
    endcase
    rsp_next.pool_free = pool_free_next;
    mem_wr.en = mem_wr.en && commit;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      pool_free <= 32'd0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        active    <= active_next;
        pool_free <= pool_free_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/pbt_checker.sv
// ----------------------------------------------------------------------------
// pbt_checker
// Port-level checks for the partition budget tracker.
// ----------------------------------------------------------------------------
module pbt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input pbt_pkg::rsp_t  rsp
);

  a_rst_clears_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == pbt_pkg::STAT_INACTIVE)) |->
      ((rsp.slot_free == 32'd0) && (rsp.slot_total == 32'd0)))
    else $error("inactive slot reported nonzero amounts");

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.slot_free <= rsp.slot_total))
    else $error("slot free exceeds slot total");

endmodule

bind partition_budget_tracker pbt_checker u_pbt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
